// ===== hw/rtl/tvsc_pkg.sv =====
`default_nettype none
package tvsc_pkg;
   localparam int MAX_NEST_DEF = 64;

   localparam logic [2:0] KIND_TAG    = 3'd0;
   localparam logic [2:0] KIND_ACOUNT = 3'd1;
   localparam logic [2:0] KIND_AINDEX = 3'd2;
   localparam logic [2:0] KIND_HCOUNT = 3'd3;
   localparam logic [2:0] KIND_STRLEN = 3'd4;
   localparam logic [2:0] KIND_NUM    = 3'd5;
   localparam logic [2:0] KIND_STRB   = 3'd6;
   localparam logic [2:0] KIND_IGN    = 3'd7;

   localparam logic [2:0] ST_BUSY  = 3'd0;
   localparam logic [2:0] ST_OK    = 3'd1;
   localparam logic [2:0] ST_EOF   = 3'd2;
   localparam logic [2:0] ST_BADTG = 3'd3;
   localparam logic [2:0] ST_DEEP  = 3'd4;
   localparam logic [2:0] ST_TRAIL = 3'd5;

   // word that passes from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } item_type;
endpackage
`default_nettype wire

// ===== hw/rtl/tvsc_if.sv =====
`default_nettype none
interface tvsc_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tvsc_front.sv =====
`default_nettype none
// Input side: two-entry queue of accepted words.
module tvsc_front
   import tvsc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          q_valid,
   output item_type      q_item,
   input  wire logic     q_take
);
   item_type  mem_ff [2];
   logic      wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;

   assign in_ready = cnt_ff != 2'd2;
   assign push     = in_valid && in_ready;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ q_take;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tvsc_back.sv =====
`default_nettype none
// Parser engine: parses each byte, then pops each table frame that it closes.
module tvsc_back
   import tvsc_pkg::*;
#(
   parameter int MAX_NEST = MAX_NEST_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] max_depth,
   input  wire logic       q_valid,
   input  wire item_type   q_item,
   output logic            q_take,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [2:0]      o_kind,
   output logic [2:0]      o_tag,
   output logic [6:0]      o_lvl,
   output logic [7:0]      o_byte,
   output logic            o_done,
   output logic [2:0]      o_status
);
   localparam int LW = $clog2(MAX_NEST + 2);
   localparam int AW = $clog2(MAX_NEST + 1);
   localparam logic [3:0] PH_TAG = 4'd0, PH_NUM = 4'd1, PH_STRLEN = 4'd2,
      PH_STRB = 4'd3, PH_ACOUNT = 4'd4, PH_AINDEX = 4'd5, PH_HCOUNT = 4'd6;
   localparam logic [1:0] M_ARR = 2'd0, M_KEY = 2'd1, M_VAL = 2'd2;

   // frame memory: mode and remaining count
   logic [33:0] fmem [MAX_NEST + 1];
   logic [33:0] top_ff;        // cached copy of frame at level-1
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [3:0]  ph_ff, ph_in;
   logic [2:0]  bc_ff, bc_in;
   logic [31:0] aw_ff, aw_in, sr_ff, sr_in;
   logic        td_ff, td_in;
   logic [2:0]  err_ff, err_in;
   logic        pop_ff, pop_in;     // closing frames, completion at level zero pending
   logic        load_ff, load_in;   // fetch top after pop
   logic [33:0] rd_ff;
   logic        out_v_ff;
   logic [2:0]  ok_ff, otg_ff, ost_ff;
   logic [6:0]  olv_ff;
   logic [7:0]  ob_ff;
   logic        od_ff;

   // per-step temporaries
   logic        fin, wr_en, done_now;
   logic [AW-1:0] wr_a;
   logic [33:0] wr_d, top_in;
   logic [2:0]  kind, vtag, status;
   logic [6:0]  lv;
   logic [31:0] word_now;
   logic        word_end;
   logic [6:0]  limit;
   logic        step;
   logic [LW-1:0] hdr;

   assign limit = (max_depth > 7'(MAX_NEST)) ? 7'(MAX_NEST) : max_depth;
   assign hdr   = (lvl_ff != '0) ? lvl_ff - 1'b1 : '0;
   assign step  = q_valid && !pop_ff && !load_ff && (!out_v_ff || out_ready);
   assign q_take = step;
   assign word_now = aw_ff | (32'(q_item.data_byte) << {bc_ff[1:0], 3'b000});
   assign word_end = bc_ff == 3'd3;

   // parse one byte, then finish_value one level using cached top frame; sets pop or load when frame closes
   always_comb begin
      lvl_in = lvl_ff; ph_in = ph_ff; bc_in = bc_ff; aw_in = aw_ff; sr_in = sr_ff;
      td_in = td_ff; err_in = err_ff; pop_in = 1'b0; load_in = 1'b0;
      top_in = top_ff; wr_en = 1'b0; wr_a = '0; wr_d = '0;
      kind = KIND_IGN; vtag = 3'd0; lv = 7'd0; done_now = 1'b0; fin = 1'b0;
      if (pop_ff) begin
         fin = 1'b1;
      end else if (load_ff) begin
         top_in = rd_ff;
         fin = 1'b1;
      end else if (step) begin
         if (err_ff != 3'd0) begin
         end else if (td_ff) begin
            err_in = ST_TRAIL;
         end else begin
            unique case (ph_ff)
               PH_TAG: begin
                  kind = KIND_TAG; lv = 7'(lvl_ff);
                  if (q_item.data_byte <= 8'd2) begin
                     vtag = q_item.data_byte[2:0]; fin = 1'b1;
                  end else if (q_item.data_byte == 8'd3) begin
                     vtag = 3'd3; ph_in = PH_NUM; bc_in = 3'd0;
                  end else if (q_item.data_byte == 8'd4) begin
                     vtag = 3'd4; ph_in = PH_STRLEN; bc_in = 3'd0; aw_in = '0;
                  end else if (q_item.data_byte == 8'd5) begin
                     vtag = 3'd5;
                     if (7'(lvl_ff) > limit) err_in = ST_DEEP;
                     else begin
                        if (lvl_ff != '0) begin
                           wr_en = 1'b1; wr_a = AW'(hdr); wr_d = top_ff;
                        end
                        top_in = {M_ARR, 32'd0};
                        lvl_in = lvl_ff + 1'b1;
                        ph_in = PH_ACOUNT; bc_in = 3'd0; aw_in = '0;
                     end
                  end else err_in = ST_BADTG;
               end
               PH_NUM: begin
                  kind = KIND_NUM; vtag = 3'd3; lv = 7'(lvl_ff);
                  bc_in = bc_ff + 3'd1;
                  if (bc_ff == 3'd7) begin bc_in = 3'd0; fin = 1'b1; end
               end
               PH_STRLEN: begin
                  kind = KIND_STRLEN; vtag = 3'd4; lv = 7'(lvl_ff);
                  aw_in = word_now; bc_in = bc_ff + 3'd1;
                  if (word_end) begin
                     bc_in = 3'd0; sr_in = word_now;
                     if (word_now == 32'd0) fin = 1'b1;
                     else ph_in = PH_STRB;
                  end
               end
               PH_STRB: begin
                  kind = KIND_STRB; vtag = 3'd4; lv = 7'(lvl_ff);
                  sr_in = sr_ff - 32'd1;
                  if (sr_ff == 32'd1) fin = 1'b1;
               end
               PH_ACOUNT: begin
                  kind = KIND_ACOUNT; vtag = 3'd5; lv = 7'(hdr);
                  aw_in = word_now; bc_in = bc_ff + 3'd1;
                  if (word_end) begin
                     bc_in = 3'd0; aw_in = '0;
                     if (word_now == 32'd0) ph_in = PH_HCOUNT;
                     else begin top_in = {M_ARR, word_now}; ph_in = PH_AINDEX; end
                  end
               end
               PH_AINDEX: begin
                  kind = KIND_AINDEX; vtag = 3'd5; lv = 7'(hdr);
                  aw_in = word_now; bc_in = bc_ff + 3'd1;
                  if (word_end) begin bc_in = 3'd0; ph_in = PH_TAG; end
               end
               default: begin
                  kind = KIND_HCOUNT; vtag = 3'd5; lv = 7'(hdr);
                  aw_in = word_now; bc_in = bc_ff + 3'd1;
                  if (word_end) begin
                     bc_in = 3'd0;
                     if (word_now == 32'd0) begin
                        if (lvl_ff != '0) begin
                           lvl_in = lvl_ff - 1'b1;
                           if (lvl_ff != LW'(1)) load_in = 1'b1;
                        end
                        if (!load_in) fin = 1'b1;
                     end else begin
                        top_in = {M_KEY, word_now}; ph_in = PH_TAG;
                     end
                  end
               end
            endcase
         end
      end
      // one level of completion, against level after this step's pops
      if (fin && !load_in) begin
         if (lvl_in == '0) begin
            td_in = 1'b1; done_now = 1'b1; ph_in = PH_TAG;
         end else if (top_in[33:32] == M_ARR) begin
            top_in[31:0] = top_in[31:0] - 32'd1;
            ph_in = (top_in[31:0] == 32'd0) ? PH_HCOUNT : PH_AINDEX;
            bc_in = 3'd0; aw_in = '0;
         end else if (top_in[33:32] == M_KEY) begin
            top_in[33:32] = M_VAL; ph_in = PH_TAG;
         end else begin
            top_in[31:0] = top_in[31:0] - 32'd1;
            if (top_in[31:0] != 32'd0) begin
               top_in[33:32] = M_KEY; ph_in = PH_TAG;
            end else begin
               lvl_in = lvl_in - 1'b1;
               if (lvl_in != '0) load_in = 1'b1;
               else pop_in = 1'b1;
            end
         end
      end
   end

   // result is issued once the whole byte, with pops, is settled
   logic       hold_last_ff, hold_done_ff;
   logic [2:0] hk_ff, ht_ff;
   logic [6:0] hl_ff;
   logic [7:0] hb_ff;
   logic       settle, busy_in;
   logic [2:0] k_s, t_s; logic [6:0] l_s; logic [7:0] b_s; logic last_s, d_s;

   assign busy_in = pop_in || load_in;
   always_comb begin
      if (step) begin
         k_s = kind; t_s = vtag; l_s = lv; b_s = q_item.data_byte;
         last_s = q_item.last; d_s = done_now;
      end else begin
         k_s = hk_ff; t_s = ht_ff; l_s = hl_ff; b_s = hb_ff;
         last_s = hold_last_ff; d_s = hold_done_ff | done_now;
      end
      settle = (step || pop_ff || load_ff) && !busy_in;
      if (last_s) status = (err_in != 3'd0) ? err_in : (td_in ? ST_OK : ST_EOF);
      else status = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (settle && last_s)) begin
         lvl_ff <= '0; ph_ff <= PH_TAG; bc_ff <= 3'd0; aw_ff <= '0; sr_ff <= '0;
         td_ff <= 1'b0; err_ff <= 3'd0; pop_ff <= 1'b0; load_ff <= 1'b0;
      end else begin
         lvl_ff <= lvl_in; ph_ff <= ph_in; bc_ff <= bc_in; aw_ff <= aw_in;
         sr_ff <= sr_in; td_ff <= td_in; err_ff <= err_in;
         pop_ff <= pop_in; load_ff <= load_in;
      end
      if (reset) out_v_ff <= 1'b0;
      else if (settle) out_v_ff <= 1'b1;
      else if (out_ready) out_v_ff <= 1'b0;
      top_ff <= top_in;
      if (wr_en) fmem[wr_a] <= wr_d;
      rd_ff <= fmem[AW'(lvl_in - 1'b1)];
      if (step || pop_ff || load_ff) begin
         hk_ff <= k_s; ht_ff <= t_s; hl_ff <= l_s; hb_ff <= b_s;
         hold_last_ff <= last_s; hold_done_ff <= d_s;
      end
      if (settle) begin
         ok_ff <= k_s; otg_ff <= t_s; olv_ff <= l_s; ob_ff <= b_s;
         od_ff <= d_s; ost_ff <= status;
      end
   end

   assign out_valid = out_v_ff;
   assign o_kind = ok_ff; assign o_tag = otg_ff; assign o_lvl = olv_ff;
   assign o_byte = ob_ff; assign o_done = od_ff; assign o_status = ost_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/tagged_value_stream_checker_core.sv =====
`default_nettype none
// channel | dir | payload
// req     | in  | data_byte[7:0], last
// rsp     | out | byte_kind, value_tag, nest_level, echo_byte, message_done, status
// csr     | in  | max_table_depth[6:0] (write only)
// Each table frame that a byte's value closes is popped in a step of its own
// after the byte (the frame below comes from a registered memory read);
// a top-level table closed by its own empty hash count needs no such step.
// Reset is synchronous and clears the parser; csr resets to 64.
// A two-word input queue decouples req from the parser; rsp is registered
// and the parser holds while a word waits on rsp.
module tagged_value_stream_checker_core
   import tvsc_pkg::*;
#(
   parameter int MAX_NEST = MAX_NEST_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   tvsc_if.sink            req,
   tvsc_if.source          rsp,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata
);
   logic [6:0] depth_ff;
   logic       q_valid, q_take;
   item_type   q_item;

   always_ff @(posedge clock) begin
      if (reset) depth_ff <= 7'd64;
      else if (csr_we) depth_ff <= csr_wdata;
   end

   tvsc_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_item(item_type'(req.payload)), .q_valid, .q_item, .q_take
   );

   tvsc_back #(.MAX_NEST(MAX_NEST)) u_back (
      .clock, .reset, .max_depth(depth_ff), .q_valid, .q_item, .q_take,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .o_kind(rsp.payload[24:22]), .o_tag(rsp.payload[21:19]),
      .o_lvl(rsp.payload[18:12]), .o_byte(rsp.payload[11:4]),
      .o_done(rsp.payload[3]), .o_status(rsp.payload[2:0])
   );
endmodule
`default_nettype wire

// ===== dv/tb_tagged_value_stream_checker_core.sv =====
`timescale 1ns / 100ps
module tb_tagged_value_stream_checker_core;
   import tvsc_pkg::*;

   localparam int RSP_W = 25;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;

   // tag byte values
   localparam logic [7:0] TAG_NIL = 8'd0;
   localparam logic [7:0] TAG_FALSE = 8'd1;
   localparam logic [7:0] TAG_TRUE = 8'd2;
   localparam logic [7:0] TAG_NUM = 8'd3;
   localparam logic [7:0] TAG_STR = 8'd4;
   localparam logic [7:0] TAG_TABLE = 8'd5;

   // parser phases and frame section modes
   typedef enum logic [3:0] {
      PH_TAG, PH_NUM, PH_STRLEN, PH_STRBYTES, PH_ACOUNT, PH_AINDEX, PH_HCOUNT
   } phase_type;
   typedef enum logic [1:0] {SEC_ARR, SEC_KEY, SEC_VAL} section_type;

   typedef struct packed {
      logic [2:0] byte_kind;
      logic [2:0] value_tag;
      logic [6:0] nest_level;
      logic [7:0] echo_byte;
      logic       message_done;
      logic [2:0] status;
   } token_type;

   typedef struct {
      logic [7:0] data_byte;
      bit         last;
      bit         typed;
      logic [2:0] kind;
      logic [2:0] status;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [6:0] csr_wdata = 7'd0;

   tvsc_if #(.W($bits(item_type))) req ();
   tvsc_if #(.W(RSP_W)) rsp ();

   tagged_value_stream_checker_core i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // parser mirror
   logic [6:0]  depth_limit_reg = 7'd64;
   logic [31:0] frame_left [0:MAX_NEST_DEF];
   section_type frame_sec [0:MAX_NEST_DEF];
   int unsigned level;
   phase_type   phase;
   int unsigned nbytes;
   logic [31:0] word_acc;
   logic [31:0] str_left;
   bit          top_done;
   logic [2:0]  err_code;
   bit          done_now;

   token_type   expected_tokens[$];
   vector_type  typed_checks[$];
   int          fail_count = 0;
   int          idle_pct = 23;
   int unsigned cycle_count = 0;
   logic [7:0]  msg[$];

   function automatic void parser_clear();
      level = 0; phase = PH_TAG; nbytes = 0; word_acc = 0;
      str_left = 0; top_done = 0; err_code = 3'd0;
   endfunction

   function automatic bit word_byte(logic [7:0] b);
      word_acc |= 32'(b) << (8 * (nbytes & 3));
      nbytes++;
      if (nbytes >= 4) begin
         nbytes = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void open_word(phase_type p);
      phase = p; nbytes = 0; word_acc = 0;
   endfunction

   // completed value: walk up through frames it closes
   function automatic void close_value();
      forever begin
         if (level == 0) begin
            top_done = 1; done_now = 1; phase = PH_TAG;
            return;
         end
         if (frame_sec[level-1] == SEC_ARR) begin
            frame_left[level-1]--;
            open_word(frame_left[level-1] == 0 ? PH_HCOUNT : PH_AINDEX);
            return;
         end
         if (frame_sec[level-1] == SEC_KEY) begin
            frame_sec[level-1] = SEC_VAL; phase = PH_TAG;
            return;
         end
         frame_left[level-1]--;
         if (frame_left[level-1] != 0) begin
            frame_sec[level-1] = SEC_KEY; phase = PH_TAG;
            return;
         end
         level--;
      end
   endfunction

   function automatic token_type tokenize(logic [7:0] b, bit last);
      token_type t;
      int unsigned lim;
      int unsigned hdr;
      lim = depth_limit_reg > MAX_NEST_DEF ? MAX_NEST_DEF : depth_limit_reg;
      hdr = level > 0 ? level - 1 : 0;
      t = '0;
      t.byte_kind = KIND_IGN;
      t.echo_byte = b;
      done_now = 0;
      if (err_code != 0) begin
      end else if (top_done) begin
         err_code = ST_TRAIL;
      end else begin
         case (phase)
            PH_TAG: begin
               t.byte_kind = KIND_TAG; t.nest_level = 7'(level);
               if (b <= TAG_TRUE) begin
                  t.value_tag = b[2:0];
                  close_value();
               end else if (b == TAG_NUM) begin
                  t.value_tag = 3'(TAG_NUM); phase = PH_NUM; nbytes = 0;
               end else if (b == TAG_STR) begin
                  t.value_tag = 3'(TAG_STR); open_word(PH_STRLEN);
               end else if (b == TAG_TABLE) begin
                  t.value_tag = 3'(TAG_TABLE);
                  if (level > lim) err_code = ST_DEEP;
                  else begin
                     frame_sec[level] = SEC_ARR; frame_left[level] = 0;
                     level++;
                     open_word(PH_ACOUNT);
                  end
               end else err_code = ST_BADTG;
            end
            PH_NUM: begin
               t.byte_kind = KIND_NUM; t.value_tag = 3'(TAG_NUM);
               t.nest_level = 7'(level);
               nbytes++;
               if (nbytes >= 8) begin
                  nbytes = 0;
                  close_value();
               end
            end
            PH_STRLEN: begin
               t.byte_kind = KIND_STRLEN; t.value_tag = 3'(TAG_STR);
               t.nest_level = 7'(level);
               if (word_byte(b)) begin
                  str_left = word_acc;
                  if (str_left == 0) close_value();
                  else phase = PH_STRBYTES;
               end
            end
            PH_STRBYTES: begin
               t.byte_kind = KIND_STRB; t.value_tag = 3'(TAG_STR);
               t.nest_level = 7'(level);
               str_left--;
               if (str_left == 0) close_value();
            end
            PH_ACOUNT: begin
               t.byte_kind = KIND_ACOUNT; t.value_tag = 3'(TAG_TABLE);
               t.nest_level = 7'(hdr);
               if (word_byte(b)) begin
                  if (word_acc == 0) open_word(PH_HCOUNT);
                  else begin
                     frame_sec[hdr] = SEC_ARR; frame_left[hdr] = word_acc;
                     open_word(PH_AINDEX);
                  end
               end
            end
            PH_AINDEX: begin
               t.byte_kind = KIND_AINDEX; t.value_tag = 3'(TAG_TABLE);
               t.nest_level = 7'(hdr);
               if (word_byte(b)) phase = PH_TAG;
            end
            default: begin
               t.byte_kind = KIND_HCOUNT; t.value_tag = 3'(TAG_TABLE);
               t.nest_level = 7'(hdr);
               if (word_byte(b)) begin
                  if (word_acc == 0) begin
                     if (level > 0) level--;
                     close_value();
                  end else begin
                     frame_sec[hdr] = SEC_KEY; frame_left[hdr] = word_acc;
                     phase = PH_TAG;
                  end
               end
            end
         endcase
      end
      t.message_done = done_now;
      if (last) begin
         t.status = err_code != 0 ? err_code : (top_done ? ST_OK : ST_EOF);
         parser_clear();
      end else t.status = err_code;
      return t;
   endfunction

   initial parser_clear();

   // accepted request words feed the mirror
   always @(posedge clock) begin
      item_type w;
      token_type t;
      vector_type v;
      cycle_count <= cycle_count + 1;
      if (!reset && req.valid && req.ready) begin
         w = req.payload;
         t = tokenize(w.data_byte, w.last);
         expected_tokens.push_back(t);
         if (typed_checks.size() > 0 && typed_checks[0].data_byte === w.data_byte
             && typed_checks[0].last == w.last) begin
            v = typed_checks.pop_front();
            if (v.typed && t.byte_kind !== v.kind) begin
               $error("byte_kind: expected %0d actual %0d (directed)", v.kind, t.byte_kind);
               fail_count++;
            end
            if (v.typed && t.status !== v.status) begin
               $error("status: expected %0d actual %0d (directed)", v.status, t.status);
               fail_count++;
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      token_type e;
      token_type a;
      if (!reset && rsp.valid && rsp.ready) begin
         a = rsp.payload;
         if (expected_tokens.size() == 0) begin
            $error("unexpected word: %h", a);
            fail_count++;
         end else begin
            e = expected_tokens.pop_front();
            if (a.byte_kind !== e.byte_kind) begin
               $error("byte_kind: expected %0d actual %0d", e.byte_kind, a.byte_kind);
               fail_count++;
            end
            if (a.value_tag !== e.value_tag) begin
               $error("value_tag: expected %0d actual %0d", e.value_tag, a.value_tag);
               fail_count++;
            end
            if (a.nest_level !== e.nest_level) begin
               $error("nest_level: expected %0d actual %0d", e.nest_level, a.nest_level);
               fail_count++;
            end
            if (a.echo_byte !== e.echo_byte) begin
               $error("echo_byte: expected %h actual %h", e.echo_byte, a.echo_byte);
               fail_count++;
            end
            if (a.message_done !== e.message_done) begin
               $error("message_done: expected %0d actual %0d", e.message_done, a.message_done);
               fail_count++;
            end
            if (a.status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, a.status);
               fail_count++;
            end
         end
      end
   end

   // result backpressure
   initial rsp.ready = 1'b0;
   always @(posedge clock) rsp.ready <= ($urandom_range(99) >= idle_pct);

   // run limit
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b, bit last);
      item_type w;
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      w.data_byte = b;
      w.last = last;
      req.valid <= 1'b1;
      req.payload <= w;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_msg();
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
   endtask

   // wait for all responses, then let the parser settle
   task automatic drain();
      req.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      depth_limit_reg = v;
      csr_we <= 1'b0;
   endtask

   function automatic void push_u32(logic [31:0] v);
      for (int i = 0; i < 4; i++) msg.push_back(v[8*i +: 8]);
   endfunction

   // well-formed value with random content
   function automatic void gen_value(int lvl, int max_lvl);
      int pick;
      int n;
      pick = $urandom_range(max_lvl > lvl ? 9 : 6);
      if (pick <= 2) msg.push_back(8'(pick));
      else if (pick <= 4) begin
         msg.push_back(TAG_NUM);
         repeat (8) msg.push_back(8'($urandom));
      end else if (pick <= 6) begin
         n = $urandom_range(4);
         msg.push_back(TAG_STR);
         push_u32(32'(n));
         repeat (n) msg.push_back(8'($urandom));
      end else begin
         msg.push_back(TAG_TABLE);
         n = $urandom_range(2);
         push_u32(32'(n));
         repeat (n) begin
            push_u32($urandom);
            gen_value(lvl + 1, max_lvl);
         end
         n = $urandom_range(2);
         push_u32(32'(n));
         repeat (n) begin
            gen_value(lvl + 1, max_lvl);
            gen_value(lvl + 1, max_lvl);
         end
      end
   endfunction

   // n tables nested through one-element arrays
   function automatic void gen_chain(int n);
      msg.delete();
      repeat (n) begin
         msg.push_back(TAG_TABLE);
         push_u32(32'd1);
         push_u32($urandom);
      end
      msg.push_back(TAG_NIL);
      repeat (n) push_u32(32'd0);
   endfunction

   task automatic random_msgs(int n_bytes);
      int sent;
      int cut;
      sent = 0;
      while (sent < n_bytes) begin
         msg.delete();
         case ($urandom_range(19))
            0: repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
            1: begin
               gen_value(0, $urandom_range(4));
               repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
            end
            2: begin
               gen_value(0, $urandom_range(4));
               cut = $urandom_range(1, msg.size());
               while (msg.size() > cut) void'(msg.pop_back());
            end
            3: begin
               gen_value(0, $urandom_range(4));
               msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
            end
            default: gen_value(0, $urandom_range(4));
         endcase
         send_msg();
         sent += msg.size();
      end
   endtask

   vector_type directed[] = '{
      '{TAG_NIL, 1, 1, KIND_TAG, ST_OK},
      '{8'hFF, 1, 1, KIND_TAG, ST_BADTG},
      '{TAG_TRUE, 0, 1, KIND_TAG, ST_BUSY},
      '{8'h00, 1, 1, KIND_IGN, ST_TRAIL},
      '{TAG_FALSE, 1, 1, KIND_TAG, ST_OK},
      '{TAG_NUM, 0, 1, KIND_TAG, ST_BUSY},
      '{8'h00, 0, 1, KIND_NUM, ST_BUSY},
      '{8'hFF, 0, 1, KIND_NUM, ST_BUSY},
      '{8'h80, 0, 0, 0, 0},
      '{8'h01, 0, 0, 0, 0},
      '{8'h7F, 0, 0, 0, 0},
      '{8'hAA, 0, 0, 0, 0},
      '{8'h55, 0, 0, 0, 0},
      '{8'hFE, 1, 1, KIND_NUM, ST_OK},
      '{TAG_STR, 0, 1, KIND_TAG, ST_BUSY},
      '{8'h00, 0, 1, KIND_STRLEN, ST_BUSY},
      '{8'h00, 0, 0, 0, 0},
      '{8'h00, 0, 0, 0, 0},
      '{8'h00, 1, 1, KIND_STRLEN, ST_OK},
      '{TAG_STR, 1, 1, KIND_TAG, ST_EOF},
      '{TAG_TABLE, 0, 1, KIND_TAG, ST_BUSY},
      '{8'h00, 0, 1, KIND_ACOUNT, ST_BUSY},
      '{8'h00, 1, 1, KIND_ACOUNT, ST_EOF},
      '{8'h06, 1, 1, KIND_TAG, ST_BADTG}
   };

   logic [6:0] limits[] = '{7'd0, 7'd1, 7'd3, 7'd127, 7'd100, 7'd64};

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset limit
      foreach (directed[i]) begin
         typed_checks.push_back(directed[i]);
         send_byte(directed[i].data_byte, directed[i].last);
      end

      // deepest legal nesting at default limit, sent with no idling
      drain();
      idle_pct = 0;
      gen_chain(65);
      send_msg();

      foreach (limits[i]) begin
         write_limit(limits[i]);
         idle_pct = (i == 2) ? 0 : 23;
         random_msgs(30);
         if (limits[i] <= 3) begin
            gen_chain(limits[i] + 2);
            send_msg();
         end
         // limit above the maximum acts as the maximum: one table too deep,
         // message ends on the offending tag
         if (limits[i] == 7'd127) begin
            gen_chain(66);
            while (msg.size() > 9 * 65 + 1) void'(msg.pop_back());
            send_msg();
         end
      end
      write_limit(7'($urandom_range(127)));
      random_msgs(30);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
